FILE: sv/ndsum_pkg.sv
package ndsum_pkg;

	localparam int PIX_W        = 8;
	localparam int WIDTH_W      = 12;
	localparam int HEIGHT_W     = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_INDEX_W  = 2;
	localparam int MAX_HEIGHT   = 4096;
	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;
	localparam int RING_ROWS    = 4;
	localparam int SLOT_W       = 2;
	localparam int QDEPTH       = 4;
	localparam int QPTR_W       = 2;
	localparam int SUM_W        = 11;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	typedef logic [PIX_W-1:0] pix_t;
	// window[row][col], row 0 is the upper row, col 0 the left column
	typedef pix_t [2:0][2:0] window_t;

	typedef struct packed {
		window_t win;
		logic    last;
	} job_t;

	// queue status as seen by the front
	typedef struct packed {
		logic full;
	} qstat_t;

endpackage

FILE: sv/ndsum_bank.sv
module ndsum_bank import ndsum_pkg::*; #(
	parameter int DEPTH = 2048,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] wa,
	input  pix_t          wd,
	input  logic          re,
	input  logic [AW-1:0] ra0,
	input  logic [AW-1:0] ra1,
	output pix_t          rd0_q,
	output pix_t          rd1_q
);

	pix_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd0_q <= mem[ra0];
			rd1_q <= mem[ra1];
		end
	end

endmodule

FILE: sv/ndsum_front.sv
module ndsum_front import ndsum_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   op,
	input  pix_t                   pixel_in,
	output logic                   push,
	output job_t                   push_job,
	input  qstat_t                 qstat
);

	localparam int AW = $clog2(MAX_WIDTH);

	logic [WIDTH_W-1:0]  width_q, col_q, ocol_q;
	logic [HEIGHT_W-1:0] height_q, row_q, orow_q;
	logic                in_done_q, out_done_q;

	logic                accept, is_pix, restart, emit, pix_emit, last;
	logic [WIDTH_W-1:0]  ec, eoc, ncol, nocol, ncol_f, nocol_f;
	logic [HEIGHT_W-1:0] er, eor, nrow_f, norow_f, r_up, r_dn;
	logic                nin_done, nout_done, eod;
	logic [WIDTH_W-1:0]  cfg_w;
	logic [HEIGHT_W-1:0] cfg_h;
	logic [AW-1:0]       wa, ra0, ra1;
	logic [SLOT_W-1:0]   wbank;

	pix_t rd0 [RING_ROWS];
	pix_t rd1 [RING_ROWS];

	logic              s1_v;
	logic [SLOT_W-1:0] up_s1, ctr_s1, dn_s1, wbank_s1;
	logic              first_s1, last_s1, hit0_s1, hit1_s1;
	pix_t              wdata_s1;
	pix_t              prev_q [3];
	pix_t              col_b [3];
	pix_t              col_n [3];
	logic [SLOT_W-1:0] slot [3];

	assign in_stall = s1_v && qstat.full;
	assign accept   = in_valid && !in_stall;
	assign is_pix   = (op == OP_PIXEL);
	assign restart  = is_pix && in_done_q;

	always_comb begin
		er  = restart ? '0 : row_q;
		ec  = restart ? '0 : col_q;
		eor = restart ? '0 : orow_q;
		eoc = restart ? '0 : ocol_q;
		eod = restart ? 1'b0 : out_done_q;

		// advance the input position
		ncol = ec + 1'b1;
		if (ncol >= width_q) begin
			ncol_f = '0;
			nrow_f = er + 1'b1;
		end else begin
			ncol_f = ncol;
			nrow_f = er;
		end
		nin_done = (nrow_f >= height_q);
		pix_emit = (nrow_f >= HEIGHT_W'(2)) || ((nrow_f == HEIGHT_W'(1)) && (ncol_f >= WIDTH_W'(2)));
		emit     = is_pix ? pix_emit : (in_done_q && !out_done_q);

		// advance the output position
		nocol = eoc + 1'b1;
		if (nocol >= width_q) begin
			nocol_f = '0;
			norow_f = eor + 1'b1;
		end else begin
			nocol_f = nocol;
			norow_f = eor;
		end
		nout_done = (norow_f >= height_q);
		last      = (eor == height_q - 1'b1) && (eoc == width_q - 1'b1);

		// reflect-101 neighbors
		r_up = (eor == '0) ? HEIGHT_W'(1) : eor - 1'b1;
		r_dn = (eor == height_q - 1'b1) ? height_q - HEIGHT_W'(2) : eor + 1'b1;

		wa    = AW'(ec);
		wbank = er[SLOT_W-1:0];
		ra0   = AW'(eoc);
		ra1   = (eoc == width_q - 1'b1) ? AW'(width_q - WIDTH_W'(2)) : AW'(nocol);

		cfg_w = cfg_data[WIDTH_W-1:0];
		if (cfg_w < WIDTH_W'(2)) begin
			cfg_w = WIDTH_W'(2);
		end else if (cfg_w > MAX_WIDTH) begin
			cfg_w = WIDTH_W'(MAX_WIDTH);
		end
		cfg_h = cfg_data[HEIGHT_W-1:0];
		if (cfg_h < HEIGHT_W'(2)) begin
			cfg_h = HEIGHT_W'(2);
		end else if (cfg_h > HEIGHT_W'(MAX_HEIGHT)) begin
			cfg_h = HEIGHT_W'(MAX_HEIGHT);
		end
	end

	// position counters and frame registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= WIDTH_W'(RESET_WIDTH);
			height_q   <= HEIGHT_W'(RESET_HEIGHT);
			row_q      <= '0;
			col_q      <= '0;
			orow_q     <= '0;
			ocol_q     <= '0;
			in_done_q  <= 1'b0;
			out_done_q <= 1'b0;
		end else if (cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT)) begin
			if (cfg_index == REG_FRAME_WIDTH) begin
				width_q <= cfg_w;
			end else begin
				height_q <= cfg_h;
			end
			row_q      <= '0;
			col_q      <= '0;
			orow_q     <= '0;
			ocol_q     <= '0;
			in_done_q  <= 1'b0;
			out_done_q <= 1'b0;
		end else if (accept) begin
			if (is_pix) begin
				row_q     <= nrow_f;
				col_q     <= ncol_f;
				in_done_q <= nin_done;
			end
			orow_q     <= emit ? norow_f : eor;
			ocol_q     <= emit ? nocol_f : eoc;
			out_done_q <= emit ? nout_done : eod;
		end
	end

	for (genvar b = 0; b < RING_ROWS; b++) begin : g_bank
		ndsum_bank #(.DEPTH(MAX_WIDTH)) u_bank (
			.clk   (clk),
			.we    (accept && is_pix && (wbank == SLOT_W'(b))),
			.wa    (wa),
			.wd    (pixel_in),
			.re    (accept),
			.ra0   (ra0),
			.ra1   (ra1),
			.rd0_q (rd0[b]),
			.rd1_q (rd1[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (accept) begin
			s1_v <= emit;
		end else if (push) begin
			s1_v <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			up_s1    <= r_up[SLOT_W-1:0];
			ctr_s1   <= eor[SLOT_W-1:0];
			dn_s1    <= r_dn[SLOT_W-1:0];
			first_s1 <= (eoc == '0);
			last_s1  <= last;
			hit0_s1  <= is_pix && (wa == ra0);
			hit1_s1  <= is_pix && (wa == ra1);
			wbank_s1 <= wbank;
			wdata_s1 <= pixel_in;
		end
	end

	// pick the three rows, forward the pixel written with this read
	always_comb begin
		slot[0] = up_s1;
		slot[1] = ctr_s1;
		slot[2] = dn_s1;
		for (int i = 0; i < 3; i++) begin
			col_b[i] = (hit0_s1 && wbank_s1 == slot[i]) ? wdata_s1 : rd0[slot[i]];
			col_n[i] = (hit1_s1 && wbank_s1 == slot[i]) ? wdata_s1 : rd1[slot[i]];
		end
		for (int i = 0; i < 3; i++) begin
			push_job.win[i][0] = first_s1 ? col_n[i] : prev_q[i];
			push_job.win[i][1] = col_b[i];
			push_job.win[i][2] = col_n[i];
		end
		push_job.last = last_s1;
	end

	assign push = s1_v && !qstat.full;

	// hold the center column as the next window's left column
	always_ff @(posedge clk) begin
		if (push) begin
			for (int i = 0; i < 3; i++) begin
				prev_q[i] <= col_b[i];
			end
		end
	end

endmodule

FILE: sv/ndsum_queue.sv
module ndsum_queue import ndsum_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  job_t   push_job,
	output qstat_t qstat,
	input  logic   pop,
	output logic   not_empty,
	output job_t   head
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0]   cnt_q;

	assign qstat.full = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign not_empty  = (cnt_q != '0);
	assign head       = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_job;
		end
	end

endmodule

FILE: sv/ndsum_back.sv
module ndsum_back import ndsum_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic not_empty,
	input  job_t head,
	output logic pop,
	output logic out_valid,
	input  logic out_stall,
	output pix_t pixel_out,
	output logic frame_last
);

	logic [SUM_W-1:0] sum;
	pix_t             ctr;
	logic             out_valid_q;

	always_comb begin
		ctr = head.win[1][1];
		sum = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (!(r == 1 && c == 1) && ctr > head.win[r][c]) begin
					sum = sum + SUM_W'(ctr - head.win[r][c]);
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign pop       = not_empty && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pixel_out  <= (sum > SUM_W'(255)) ? 8'hFF : sum[PIX_W-1:0];
			frame_last <= head.last;
		end
	end

endmodule

FILE: sv/neighbor_difference_sum_3x3_top.sv
// Eight-neighbor difference sum over a 3x3 window. Pixels arrive in raster
// order, one per transaction, at up to one per clock; each result is the sum
// of max(0, center - neighbor) over the eight neighbors, saturated at 255,
// with reflect-101 borders. The result for a pixel comes out with the pixel
// one row plus one pixel later; once the frame's last pixel is in, drain
// items (op = 1) flush the last frame_width + 1 results, one each. Drains
// that find nothing pending give no result. A pixel after a full frame
// starts the next frame. Writing frame_width (index 0, clamped 2..MAX_WIDTH)
// or frame_height (index 1, clamped 2..4096) restarts the frame; write only
// while idle. A result passes from the line-store read, registered at the
// edge that accepts its item, through the queue to the output register;
// the sustained rate is one item per clock while neither side stalls, set
// by the single write and two reads per line-store bank.
module neighbor_difference_sum_3x3_top import ndsum_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   op,
	input  logic [7:0]             pixel_in,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             pixel_out,
	output logic                   frame_last
);

	logic   push, pop, not_empty;
	job_t   push_job, head;
	qstat_t qstat;

	// front: count positions, fill the line store, assemble windows
	ndsum_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.pixel_in  (pixel_in),
		.push      (push),
		.push_job  (push_job),
		.qstat     (qstat)
	);

	// short queue of windows so each side can stall on its own
	ndsum_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.qstat     (qstat),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	// back: sum differences, saturate, hold in the output register
	ndsum_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.not_empty  (not_empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_out  (pixel_out),
		.frame_last (frame_last)
	);

endmodule
